>>> design/osm_pkg.sv
package osm_pkg;

  // fixed field widths
  localparam int OP_W   = 1;
  localparam int VAL_W  = 10;
  localparam int RANK_W = 13;

  // default sizing
  localparam int DEF_VALUE_RANGE = 1024;
  localparam int DEF_MAX_ENTRIES = 4096;

  // opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic clr;       // write one zero entry of the clearing pass
    logic load;      // capture an accepted transaction
    logic start;     // evaluate bounds, latch flag, bump total
    logic ins_wr;    // write incremented count, advance tree index
    logic qry_step;  // one level of the descent
    logic res_load;  // load the output register
  } osm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic is_query;
    logic ins_ok;
    logic qry_ok;
    logic ins_more;
    logic qry_last;
  } osm_stat_t;

endpackage

>>> design/osm_in_if.sv
interface osm_in_if;
  import osm_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [VAL_W-1:0]  value;
  logic [RANK_W-1:0] rank;

  modport source (output valid, output opcode, output value, output rank, input ready);
  modport sink   (input valid, input opcode, input value, input rank, output ready);
endinterface

>>> design/osm_out_if.sv
interface osm_out_if;
  import osm_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] result_value;
  logic             found;
  logic             full_error;

  modport source (output valid, output result_value, output found, output full_error,
                  input ready);
  modport sink   (input valid, input result_value, input found, input full_error,
                  output ready);
endinterface

>>> design/order_statistic_multiset.sv
// channel   dir  handshake     payload
// in_ch     in   valid/ready   opcode, value, rank
// out_ch    out  valid/ready   result_value, found, full_error
//
// an insert updates tree nodes upward from its value, fewer for high values, and
// a query descends level by level; an update is a read then a write and a level
// a read then a compare on the single node memory; rejected items skip the tree
// after reset a clearing pass writes one node a cycle over the rounded-up value
// range with in_ready held low
// a stalled output holds only the finished result; the next transaction is accepted
module order_statistic_multiset #(
  parameter int VALUE_RANGE = osm_pkg::DEF_VALUE_RANGE,
  parameter int MAX_ENTRIES = osm_pkg::DEF_MAX_ENTRIES
) (
  input logic       clk,
  input logic       rst_n,
  osm_in_if.sink    in_ch,
  osm_out_if.source out_ch
);
  import osm_pkg::*;

  osm_cmd_t  cmd;
  osm_stat_t stat;

  // sequencer
  osm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // fenwick tree datapath
  osm_datapath #(
    .VALUE_RANGE (VALUE_RANGE),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_opcode (in_ch.opcode),
    .in_value  (in_ch.value),
    .in_rank   (in_ch.rank),
    .res_value (out_ch.result_value),
    .res_found (out_ch.found),
    .res_full  (out_ch.full_error)
  );

`ifndef SYNTH
  // one transaction at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while an item is in flight");

  // output register never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // clearing pass blocks input
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !in_ch.ready)
    else $error("input ready during clearing pass");

  // a result is never both found and dropped
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.found && out_ch.full_error))
    else $error("found and full_error both set");
`endif

endmodule

>>> design/osm_ram.sv
module osm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/osm_datapath.sv
module osm_datapath #(
  parameter int VALUE_RANGE = osm_pkg::DEF_VALUE_RANGE,
  parameter int MAX_ENTRIES = osm_pkg::DEF_MAX_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  osm_pkg::osm_cmd_t          cmd,
  output osm_pkg::osm_stat_t         stat,
  input  logic [osm_pkg::OP_W-1:0]   in_opcode,
  input  logic [osm_pkg::VAL_W-1:0]  in_value,
  input  logic [osm_pkg::RANK_W-1:0] in_rank,
  output logic [osm_pkg::VAL_W-1:0]  res_value,
  output logic                       res_found,
  output logic                       res_full
);
  import osm_pkg::*;

  localparam int LOG  = $clog2(VALUE_RANGE);
  localparam int AW   = LOG;
  localparam int IW   = LOG + 1;
  localparam int TS   = 1 << LOG;
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [RANK_W-1:0] rem_r, rem_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     bit_r, bit_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     total_r, total_nxt;
  logic              flag_r, flag_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  logic              res_found_r, res_found_nxt;
  logic              res_full_r, res_full_nxt;

  logic [AW-1:0]     cand;
  logic [IW-1:0]     lowbit;
  logic [IW:0]       idx_sum;
  logic              full;
  logic              val_ok;
  logic              qry_ok;
  logic              tree_lt;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CW-1:0]     mem_rdata;

  // fenwick node counts
  osm_ram #(
    .WIDTH (CW),
    .DEPTH (TS)
  ) u_tree (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // tree index and descent helpers
  assign cand    = pos_r | bit_r;
  assign lowbit  = idx_r & (~idx_r + 1'b1);
  assign idx_sum = {1'b0, idx_r} + {1'b0, lowbit};
  assign full    = 32'(total_r) >= 32'(MAX_ENTRIES);
  assign val_ok  = 32'(val_r) < 32'(VALUE_RANGE);
  assign qry_ok  = (rem_r != '0) && (CMPW'(rem_r) <= CMPW'(total_r));
  assign tree_lt = CMPW'(mem_rdata) < CMPW'(rem_r);

  // memory port steering; index TS wraps to address zero
  assign mem_we    = cmd.clr | cmd.ins_wr;
  assign mem_waddr = cmd.clr ? clr_addr_r : idx_r[AW-1:0];
  assign mem_wdata = cmd.clr ? '0 : mem_rdata + 1'b1;
  assign mem_raddr = (op_r == OP_QUERY) ? cand : idx_r[AW-1:0];

  // status back to controller
  always_comb begin
    stat.clr_done = (clr_addr_r == {AW{1'b1}});
    stat.is_query = (op_r == OP_QUERY);
    stat.ins_ok   = !full && val_ok;
    stat.qry_ok   = qry_ok;
    stat.ins_more = idx_sum <= (IW + 1)'(TS);
    stat.qry_last = bit_r[0];
  end

  // next-state logic
  always_comb begin
    op_nxt        = op_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    flag_nxt      = flag_r;
    clr_addr_nxt  = clr_addr_r;
    res_value_nxt = res_value_r;
    res_found_nxt = res_found_r;
    res_full_nxt  = res_full_r;

    if (cmd.clr) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
    end

    if (cmd.load) begin
      op_nxt  = in_opcode;
      val_nxt = in_value;
      rem_nxt = in_rank;
      pos_nxt = '0;
      bit_nxt = AW'(1) << (AW - 1);
      idx_nxt = IW'(32'(in_value) + 32'd1);
    end

    if (cmd.start) begin
      flag_nxt = (op_r == OP_QUERY) ? qry_ok : full;
      if ((op_r == OP_INSERT) && !full && val_ok) begin
        total_nxt = total_r + 1'b1;
      end
    end

    if (cmd.ins_wr) begin
      idx_nxt = idx_sum[IW-1:0];
    end

    // take the right branch when the left subtree is too small
    if (cmd.qry_step) begin
      if (tree_lt) begin
        pos_nxt = cand;
        rem_nxt = RANK_W'(CMPW'(rem_r) - CMPW'(mem_rdata));
      end
      bit_nxt = bit_r >> 1;
    end

    if (cmd.res_load) begin
      res_found_nxt = (op_r == OP_QUERY) && flag_r;
      res_full_nxt  = (op_r == OP_INSERT) && flag_r;
      res_value_nxt = ((op_r == OP_QUERY) && flag_r) ? VAL_W'(pos_r) : '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      clr_addr_r <= '0;
    end else begin
      total_r    <= total_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    val_r       <= val_nxt;
    rem_r       <= rem_nxt;
    pos_r       <= pos_nxt;
    bit_r       <= bit_nxt;
    idx_r       <= idx_nxt;
    flag_r      <= flag_nxt;
    res_value_r <= res_value_nxt;
    res_found_r <= res_found_nxt;
    res_full_r  <= res_full_nxt;
  end

  assign res_value = res_value_r;
  assign res_found = res_found_r;
  assign res_full  = res_full_r;

endmodule

>>> design/osm_ctrl.sv
module osm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  osm_pkg::osm_stat_t stat,
  output osm_pkg::osm_cmd_t  cmd
);
  import osm_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_INS_RD = 3'd3;
  localparam logic [2:0] S_INS_WR = 3'd4;
  localparam logic [2:0] S_QRY_RD = 3'd5;
  localparam logic [2:0] S_QRY_CMP = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        if (stat.is_query) begin
          state_nxt = stat.qry_ok ? S_QRY_RD : S_FIN;
        end else begin
          state_nxt = stat.ins_ok ? S_INS_RD : S_FIN;
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = stat.ins_more ? S_INS_RD : S_FIN;
      end
      S_QRY_RD: begin
        state_nxt = S_QRY_CMP;
      end
      S_QRY_CMP: begin
        cmd.qry_step = 1'b1;
        state_nxt    = stat.qry_last ? S_FIN : S_QRY_RD;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import osm_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [VAL_W-1:0]  value;
    logic [RANK_W-1:0] rank;
  } osm_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] result_value;
    logic             found;
    logic             full_error;
  } osm_result_t;

  logic clk = 1'b0;
  logic rst_n;

  osm_in_if  in_if ();
  osm_out_if out_if ();

  order_statistic_multiset dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // pending stimulus and results still owed by the block
  osm_item_t   stimulus_q[$];
  osm_result_t pending_results[$];

  // shadow multiset: copies per value and number of stored entries
  logic [RANK_W-1:0] stored_count [DEF_VALUE_RANGE];
  logic [RANK_W-1:0] stored_total;

  // entry count as seen by the stimulus planner
  int planned_total = 0;
  int error_count   = 0;

  // driver and monitor state
  osm_item_t drv_item;
  logic      drv_busy  = 1'b0;
  int        drv_gap   = 0;
  int        drv_burst = 0;
  int        mon_wait  = 0;
  int        mon_burst = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reset and known levels from time zero
  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.opcode  = OP_INSERT;
    in_if.value   = '0;
    in_if.rank    = '0;
    out_if.ready  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // idle cycles before the next transaction, with occasional back-to-back runs
  function automatic int draw_idle(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // apply one transaction to the shadow multiset and return the result it owes
  function automatic osm_result_t multiset_step(osm_item_t it);
    osm_result_t r;
    int          acc;
    int          v;
    r = '0;
    if (it.opcode == OP_INSERT) begin
      if (stored_total >= DEF_MAX_ENTRIES) begin
        r.full_error = 1'b1;
      end else begin
        stored_count[it.value] = stored_count[it.value] + 1'b1;
        stored_total = stored_total + 1'b1;
      end
    end else if (it.rank != 0 && it.rank <= stored_total) begin
      // smallest value whose prefix count reaches the rank
      acc = 0;
      for (v = 0; v < DEF_VALUE_RANGE && !r.found; v++) begin
        acc += stored_count[v];
        if (acc >= it.rank) begin
          r.found        = 1'b1;
          r.result_value = v[VAL_W-1:0];
        end
      end
    end
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      foreach (stored_count[i]) stored_count[i] = '0;
      stored_total = '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pending_results = {pending_results, multiset_step(drv_item)};
        drv_busy = 1'b0;
      end
      if (!drv_busy && stimulus_q.size() > 0) begin
        drv_item = stimulus_q.pop_front();
        drv_gap  = draw_idle(drv_burst);
        drv_busy = 1'b1;
      end
      if (drv_busy && drv_gap == 0) begin
        in_if.valid  <= 1'b1;
        in_if.opcode <= drv_item.opcode;
        in_if.value  <= drv_item.value;
        in_if.rank   <= drv_item.rank;
      end else begin
        in_if.valid <= 1'b0;
        if (drv_busy) drv_gap--;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    osm_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      mon_wait = draw_idle(mon_burst);
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected: value %0d found %0d full %0d",
                 out_if.result_value, out_if.found, out_if.full_error);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value,
                   out_if.result_value);
            error_count++;
          end
          if (out_if.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_if.found);
            error_count++;
          end
          if (out_if.full_error !== want.full_error) begin
            $error("full_error: expected %0d, got %0d", want.full_error,
                   out_if.full_error);
            error_count++;
          end
        end
        mon_wait = draw_idle(mon_burst);
      end
      if (mon_wait == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        mon_wait--;
      end
    end
  end

  // queue an insert; the rank field is don't-care and gets random bits
  function automatic void queue_insert(int v);
    osm_item_t it;
    it.opcode = OP_INSERT;
    it.value  = v[VAL_W-1:0];
    it.rank   = RANK_W'($urandom_range(0, 8191));
    stimulus_q = {stimulus_q, it};
    if (planned_total < DEF_MAX_ENTRIES) planned_total++;
  endfunction

  // queue a k-th smallest lookup; the value field is don't-care
  function automatic void queue_query(int k);
    osm_item_t it;
    it.opcode = OP_QUERY;
    it.value  = VAL_W'($urandom_range(0, 1023));
    it.rank   = k[RANK_W-1:0];
    stimulus_q = {stimulus_q, it};
  endfunction

  // stimulus plan and end of run
  initial begin : stimulus_plan
    int k;
    int pick;

    // lookups on an empty store
    queue_query(1);
    queue_query(0);
    // extremes and alternating bit patterns, with a duplicate
    queue_insert(0);
    queue_insert(1023);
    queue_insert(1023);
    queue_insert(10'h155);
    queue_insert(10'h2aa);
    queue_insert(512);
    // every rank in range, zero, one past the end and far out of range
    for (k = 0; k <= 7; k++) queue_query(k);
    queue_query(8191);
    queue_query(4096);
    queue_query(13'h0aaa);
    queue_query(13'h1555);

    // random mix of inserts and lookups, with a full drain halfway
    for (k = 0; k < 1000; k++) begin
      if (k == 500) begin
        // hold off until every owed result has come back
        do @(negedge clk);
        while (stimulus_q.size() != 0 || drv_busy || pending_results.size() != 0);
      end
      pick = $urandom_range(0, 7);
      if ($urandom_range(0, 19) < 11) begin
        if (pick < 2) queue_insert($urandom_range(0, 15));
        else if (pick == 2) queue_insert($urandom_range(0, 1) ? 1023 : 0);
        else queue_insert($urandom_range(0, 1023));
      end else begin
        if (pick == 0) queue_query(0);
        else if (pick == 1) queue_query(planned_total + $urandom_range(1, 3));
        else if (pick == 2 || planned_total == 0) queue_query($urandom_range(0, 8191));
        else queue_query($urandom_range(1, planned_total));
      end
    end

    // extreme values, lookups at the top and past the end
    queue_insert(0);
    queue_insert(1023);
    queue_query(planned_total);
    queue_query(planned_total + 1);
    queue_insert($urandom_range(0, 1023));
    queue_query(1);
    queue_query(2048);
    queue_query(8191);
    queue_insert(10'h155);
    queue_query(0);

    // drain, then give a stray extra result time to show up
    do @(negedge clk);
    while (stimulus_q.size() != 0 || drv_busy || pending_results.size() != 0);
    repeat (40) @(negedge clk);

    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("timeout: %0d items unsent, %0d results outstanding",
             stimulus_q.size(), pending_results.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
